>>> src/hcs_pkg.sv
// Package for the histogram cosine similarity block: sizes, command codes,
// reset values and derived widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcs_pkg;

	localparam int BINS      = 128;
	localparam int MAX_COUNT = 4096;

	localparam int CHAR_W = 7;
	localparam int CMD_W  = 2;
	localparam int THR_W  = 16;
	localparam int SIM_W  = 16;

	localparam int BIN_W  = $clog2(BINS);
	localparam int EXT_W  = (BIN_W > CHAR_W) ? BIN_W : CHAR_W;
	localparam int CNT_W  = $clog2(MAX_COUNT + 1);

	localparam longint SUM_MAX = longint'(BINS) * longint'(MAX_COUNT) * longint'(MAX_COUNT);
	localparam int SUM_W  = $clog2(SUM_MAX + 1);
	localparam int PROD_W = 2 * SUM_W;
	// Room for dot^2 * 2^30 and for every trial square times the norm product.
	localparam int BIG_W  = PROD_W + 33;

	localparam int FRAC_BITS = 15;
	localparam int K_W       = 4;

	localparam logic [CMD_W-1:0] CMD_REF    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QRY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIN    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [CHAR_W-1:0] SPACE_CODE   = 7'd32;
	localparam logic [THR_W-1:0]  THRESH_RESET = 16'd28378;
	localparam logic [SIM_W-1:0]  ONE_Q15      = 16'd32768;

endpackage
`default_nettype wire

>>> src/hcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module hcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> src/histogram_cosine_similarity.sv
// Top level of the histogram cosine similarity block: sequencer, shared
// multiplier and square-root search. Depends on hcs_pkg and hcs_ram.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   command, character
// out       output     out_valid/out_stall similarity, matches_res, empty_res
// cfg       input      cfg_we              cfg_wdata (match threshold)
//
// A counted character reads its bin and then writes it back; a character that
// is not counted, and command 3, are taken without leaving the idle state.
// A finish sweeps the bins on the one shared multiplier (bin read, load, then the
// dot, reference norm and query norm products), forms the norm product and dot
// square, finds the 15 result bits one at a time and waits for a free output register.
// Reset clears the histogram valid bits and the space flag and restores the threshold.
// Characters are accepted while a result waits; a finish waits for the register.
`timescale 1ns / 1ps
`default_nettype none
module histogram_cosine_similarity (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [hcs_pkg::CMD_W-1:0]   command,
	input  wire logic [hcs_pkg::CHAR_W-1:0]  character,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [hcs_pkg::SIM_W-1:0]   similarity,
	output logic                             matches_res,
	output logic                             empty_res,
	input  wire logic                        cfg_we,
	input  wire logic [hcs_pkg::THR_W-1:0]   cfg_wdata
);

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_CH_WR = 16'h0002,
		ST_SW_RD = 16'h0004,
		ST_SW_LD = 16'h0008,
		ST_SW_M0 = 16'h0010,
		ST_SW_M1 = 16'h0020,
		ST_SW_M2 = 16'h0040,
		ST_SW_M3 = 16'h0080,
		ST_FIN_P = 16'h0100,
		ST_FIN_D = 16'h0200,
		ST_FIN_R = 16'h0400,
		ST_SR_A  = 16'h0800,
		ST_SR_B  = 16'h1000,
		ST_SR_C  = 16'h2000,
		ST_DONE  = 16'h4000
	} state_t;

	state_t state_q;

	logic [hcs_pkg::THR_W-1:0] thr_q;
	logic                      seen_space_q;
	logic [hcs_pkg::BINS-1:0]  ref_vld_q;
	logic [hcs_pkg::BINS-1:0]  qry_vld_q;
	logic                      sel_qry_q;
	logic [hcs_pkg::BIN_W-1:0] addr_q;
	logic [hcs_pkg::BIN_W-1:0] idx_q;

	logic [hcs_pkg::CNT_W-1:0] a_q, b_q;
	logic [hcs_pkg::SUM_W-1:0] dot_q, nr_q, nq_q;
	logic [hcs_pkg::PROD_W-1:0] mul_q, p_q;
	logic [hcs_pkg::BIG_W-1:0] r_q, t_q, u_q, c_q;
	logic [hcs_pkg::K_W-1:0]   k_q;
	logic [hcs_pkg::SIM_W-1:0] s_q;
	logic                      empty_q;

	logic                      out_valid_q;
	logic [hcs_pkg::SIM_W-1:0] sim_q;
	logic                      match_q;
	logic                      out_empty_q;

	logic [hcs_pkg::EXT_W-1:0] ch_ext;
	logic [hcs_pkg::BIN_W-1:0] ch_idx;
	logic                      ch_in_range;
	logic                      in_acc;
	logic                      out_free;

	logic [hcs_pkg::BIN_W-1:0] raddr;
	logic [hcs_pkg::CNT_W-1:0] ref_rdata, qry_rdata;
	logic [hcs_pkg::CNT_W-1:0] old_cnt, new_cnt;
	logic                      ref_we, qry_we;

	logic [hcs_pkg::SUM_W-1:0] mul_a, mul_b;
	logic [hcs_pkg::BIG_W-1:0] p_ext;
	logic [4:0]                sh_u, sh_p;

	assign ch_ext      = hcs_pkg::EXT_W'(character);
	assign ch_idx      = ch_ext[hcs_pkg::BIN_W-1:0];
	assign ch_in_range = (int'(character) < hcs_pkg::BINS);
	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;

	assign raddr = (state_q == ST_IDLE) ? ch_idx : idx_q;

	// Bin update: an entry that has not been written since the last clear reads as zero.
	assign old_cnt = sel_qry_q ? (qry_vld_q[addr_q] ? qry_rdata : '0)
	                           : (ref_vld_q[addr_q] ? ref_rdata : '0);
	assign new_cnt = (old_cnt < hcs_pkg::CNT_W'(hcs_pkg::MAX_COUNT)) ?
	                 old_cnt + hcs_pkg::CNT_W'(1) : old_cnt;
	assign ref_we  = (state_q == ST_CH_WR) && !sel_qry_q;
	assign qry_we  = (state_q == ST_CH_WR) && sel_qry_q;

	hcs_ram #(.WIDTH(hcs_pkg::CNT_W), .DEPTH(hcs_pkg::BINS)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (addr_q),
		.wdata (new_cnt),
		.raddr (raddr),
		.rdata (ref_rdata)
	);

	hcs_ram #(.WIDTH(hcs_pkg::CNT_W), .DEPTH(hcs_pkg::BINS)) u_qry_ram (
		.clk   (clk),
		.we    (qry_we),
		.waddr (addr_q),
		.wdata (new_cnt),
		.raddr (raddr),
		.rdata (qry_rdata)
	);

	always_comb begin
		mul_a = hcs_pkg::SUM_W'(a_q);
		mul_b = hcs_pkg::SUM_W'(b_q);
		unique case (state_q)
			ST_SW_M1: mul_b = hcs_pkg::SUM_W'(a_q);
			ST_SW_M2: mul_a = hcs_pkg::SUM_W'(b_q);
			ST_FIN_P: begin
				mul_a = nr_q;
				mul_b = nq_q;
			end
			ST_FIN_D: begin
				mul_a = dot_q;
				mul_b = dot_q;
			end
			default: ;
		endcase
	end

	// Trial of bit k: (s + 2^k)^2 P = s^2 P + 2^(k+1) s P + 2^(2k) P.
	assign p_ext = hcs_pkg::BIG_W'(p_q);
	assign sh_u  = 5'(k_q) + 5'd1;
	assign sh_p  = {k_q, 1'b0};

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thr_q        <= hcs_pkg::THRESH_RESET;
			seen_space_q <= 1'b0;
			ref_vld_q    <= '0;
			qry_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			// A result loaded in the done state replaces the one leaving here.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (command == hcs_pkg::CMD_REF) begin
							sel_qry_q <= 1'b0;
							addr_q    <= ch_idx;
							if (ch_in_range) begin
								state_q <= ST_CH_WR;
							end
						end else if (command == hcs_pkg::CMD_QRY) begin
							sel_qry_q <= 1'b1;
							addr_q    <= ch_idx;
							if (character == hcs_pkg::SPACE_CODE) begin
								seen_space_q <= 1'b1;
							end else if (seen_space_q && ch_in_range) begin
								state_q <= ST_CH_WR;
							end
						end else if (command == hcs_pkg::CMD_FIN) begin
							idx_q   <= '0;
							dot_q   <= '0;
							nr_q    <= '0;
							nq_q    <= '0;
							state_q <= ST_SW_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CH_WR: begin
					if (sel_qry_q) begin
						qry_vld_q[addr_q] <= 1'b1;
					end else begin
						ref_vld_q[addr_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SW_RD: state_q <= ST_SW_LD;
				ST_SW_LD: begin
					a_q     <= ref_vld_q[idx_q] ? ref_rdata : '0;
					b_q     <= qry_vld_q[idx_q] ? qry_rdata : '0;
					state_q <= ST_SW_M0;
				end
				ST_SW_M0: state_q <= ST_SW_M1;
				ST_SW_M1: begin
					dot_q   <= dot_q + mul_q[hcs_pkg::SUM_W-1:0];
					state_q <= ST_SW_M2;
				end
				ST_SW_M2: begin
					nr_q    <= nr_q + mul_q[hcs_pkg::SUM_W-1:0];
					state_q <= ST_SW_M3;
				end
				ST_SW_M3: begin
					nq_q <= nq_q + mul_q[hcs_pkg::SUM_W-1:0];
					if (idx_q == hcs_pkg::BIN_W'(hcs_pkg::BINS - 1)) begin
						state_q <= ST_FIN_P;
					end else begin
						idx_q   <= idx_q + hcs_pkg::BIN_W'(1);
						state_q <= ST_SW_RD;
					end
				end
				ST_FIN_P: state_q <= ST_FIN_D;
				ST_FIN_D: begin
					p_q     <= mul_q;
					state_q <= ST_FIN_R;
				end
				ST_FIN_R: begin
					r_q     <= hcs_pkg::BIG_W'(mul_q) << 30;
					empty_q <= (nr_q == '0) || (nq_q == '0);
					t_q     <= '0;
					u_q     <= '0;
					k_q     <= hcs_pkg::K_W'(hcs_pkg::FRAC_BITS - 1);
					priority if ((nr_q == '0) || (nq_q == '0)) begin
						s_q     <= '0;
						state_q <= ST_DONE;
					end else if (mul_q == p_q) begin
						// Parallel histograms: the cosine is exactly one.
						s_q     <= hcs_pkg::ONE_Q15;
						state_q <= ST_DONE;
					end else begin
						s_q     <= '0;
						state_q <= ST_SR_A;
					end
				end
				ST_SR_A: begin
					c_q     <= t_q + (u_q << sh_u);
					state_q <= ST_SR_B;
				end
				ST_SR_B: begin
					c_q     <= c_q + (p_ext << sh_p);
					state_q <= ST_SR_C;
				end
				ST_SR_C: begin
					if (c_q <= r_q) begin
						s_q[k_q] <= 1'b1;
						t_q      <= c_q;
						u_q      <= u_q + (p_ext << k_q);
					end
					if (k_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q - hcs_pkg::K_W'(1);
						state_q <= ST_SR_A;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						sim_q        <= s_q;
						match_q      <= !empty_q && (s_q >= thr_q);
						out_empty_q  <= empty_q;
						ref_vld_q    <= '0;
						qry_vld_q    <= '0;
						seen_space_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign similarity  = sim_q;
	assign matches_res = match_q;
	assign empty_res   = out_empty_q;

endmodule
`default_nettype wire

>>> src/hcs_chk.sv
// Port-level checker for the histogram cosine similarity block and its bind.
// Depends on hcs_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module hcs_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic [hcs_pkg::CMD_W-1:0]  command,
	input wire logic [hcs_pkg::CHAR_W-1:0] character,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [hcs_pkg::SIM_W-1:0]  similarity,
	input wire logic                       matches_res,
	input wire logic                       empty_res,
	input wire logic                       cfg_we,
	input wire logic [hcs_pkg::THR_W-1:0]  cfg_wdata
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(similarity) &&
		$stable(matches_res) && $stable(empty_res))
		else $error("stalled result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> (similarity == '0) && !matches_res)
		else $error("empty result with nonzero similarity or match");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> similarity <= hcs_pkg::ONE_Q15)
		else $error("similarity above one");

	// A finish transaction starts a sweep that stalls the input.
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == hcs_pkg::CMD_FIN) |=> in_stall)
		else $error("input taken right after finish");

endmodule

bind histogram_cosine_similarity hcs_chk u_hcs_chk (.*);
`default_nettype wire
